### hdl/tfdr_pkg.sv
// ----------------------------------------------------------------------------
// tfdr_pkg: shared types, constants and control store of the fan duty ramp
// Holds the microcode table, its field encodings and the divider control.
// ----------------------------------------------------------------------------
package tfdr_pkg;

  // Command codes carried in the low bits of the input tuser.
  localparam logic [1:0] CMD_SET     = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  localparam int        FAN_COUNT   = 3;
  localparam logic [1:0] FAN_LIMIT  = 2'd3;
  localparam logic [15:0] PASSTHROUGH = 16'hFFFF;
  localparam logic [15:0] FAN0_RESET  = 16'h0020;
  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  // speed mod 321 by reciprocal: q = (speed * 52266) >> 24 is exact for 16 bits.
  localparam logic [15:0] MOD321_RECIP = 16'd52266;
  localparam int          MOD321_SHIFT = 24;
  localparam logic [16:0] MOD321       = 17'd321;

  // Restoring divider: 32-bit dividend, 16-bit divisor and quotient.
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef struct packed {
    logic init;
    logic step;
  } div_ctrl_t;

  // Microcode word layout.
  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_MODQ,
    OP_WRITE,
    OP_LOAD,
    OP_MUL,
    OP_DINIT,
    OP_DSTEP,
    OP_STORE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_DISPATCH,
    JMP_DIV_LOOP,
    JMP_OUT_WAIT
  } jmp_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] fan;
    jmp_t       jmp;
    pc_t        target;
  } uword_t;

  localparam pc_t PC_IDLE = 5'd0;
  localparam pc_t PC_SET  = 5'd1;
  localparam pc_t PC_TICK = 5'd3;
  localparam pc_t PC_LAST = 5'd18;

  // Control store. Each fan's ramp takes load, multiply, divider setup,
  // sixteen divider steps and a store.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      5'd0:    w = '{OP_NOP,   2'd0, JMP_DISPATCH, PC_IDLE};
      5'd1:    w = '{OP_MODQ,  2'd0, JMP_NEXT,     PC_IDLE};
      5'd2:    w = '{OP_WRITE, 2'd0, JMP_ALWAYS,   PC_IDLE};
      5'd3:    w = '{OP_LOAD,  2'd0, JMP_NEXT,     PC_IDLE};
      5'd4:    w = '{OP_MUL,   2'd0, JMP_NEXT,     PC_IDLE};
      5'd5:    w = '{OP_DINIT, 2'd0, JMP_NEXT,     PC_IDLE};
      5'd6:    w = '{OP_DSTEP, 2'd0, JMP_DIV_LOOP, pc};
      5'd7:    w = '{OP_STORE, 2'd0, JMP_NEXT,     PC_IDLE};
      5'd8:    w = '{OP_LOAD,  2'd1, JMP_NEXT,     PC_IDLE};
      5'd9:    w = '{OP_MUL,   2'd1, JMP_NEXT,     PC_IDLE};
      5'd10:   w = '{OP_DINIT, 2'd1, JMP_NEXT,     PC_IDLE};
      5'd11:   w = '{OP_DSTEP, 2'd1, JMP_DIV_LOOP, pc};
      5'd12:   w = '{OP_STORE, 2'd1, JMP_NEXT,     PC_IDLE};
      5'd13:   w = '{OP_LOAD,  2'd2, JMP_NEXT,     PC_IDLE};
      5'd14:   w = '{OP_MUL,   2'd2, JMP_NEXT,     PC_IDLE};
      5'd15:   w = '{OP_DINIT, 2'd2, JMP_NEXT,     PC_IDLE};
      5'd16:   w = '{OP_DSTEP, 2'd2, JMP_DIV_LOOP, pc};
      5'd17:   w = '{OP_STORE, 2'd2, JMP_NEXT,     PC_IDLE};
      5'd18:   w = '{OP_EMIT,  2'd0, JMP_OUT_WAIT, PC_IDLE};
      default: w = '{OP_NOP,   2'd0, JMP_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/tfdr_divider.sv
// ----------------------------------------------------------------------------
// tfdr_divider: restoring unsigned divider, one quotient bit per stepped cycle
// The caller guarantees the quotient fits in DIV_W bits.
// ----------------------------------------------------------------------------
module tfdr_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  tfdr_pkg::div_ctrl_t               ctrl,
  input  logic [2*tfdr_pkg::DIV_W-1:0]      dividend,
  input  logic [tfdr_pkg::DIV_W-1:0]        divisor,
  output logic [tfdr_pkg::DIV_W-1:0]        quotient,
  output logic                              last
);

  localparam int W = tfdr_pkg::DIV_W;

  logic [W-1:0]                   rem;
  logic [W-1:0]                   quo;
  logic [tfdr_pkg::DIV_CNT_W-1:0] cnt;
  logic [W:0]                     trial;

  // Shift in the next dividend bit and try to take the divisor.
  assign trial = {rem, quo[W-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.init) begin
      cnt <= tfdr_pkg::DIV_CNT_W'(W);
    end else if (ctrl.step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      rem <= dividend[2*W-1:W];
      quo <= dividend[W-1:0];
    end else if (ctrl.step) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
      end
      quo <= {quo[W-2:0], ~trial[W]};
    end
  end

  assign quotient = quo;
  assign last     = (cnt == tfdr_pkg::DIV_CNT_W'(1));

endmodule

### hdl/three_fan_duty_ramp_unit.sv
// ----------------------------------------------------------------------------
// three_fan_duty_ramp_unit: linear soft-start duty ramp for three fans
// A tick transaction runs three divider passes, then loads its result into the
// output register; the next transaction is taken in the cycle after the result
// is loaded. Synchronous reset restores fan targets and clears the count.
// ----------------------------------------------------------------------------
module three_fan_duty_ramp_unit (
  input  logic        clk,
  input  logic        rst,
  // Configuration: ramp duration in milliseconds.
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  // Command stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] speed
  input  logic [3:0]  s_tuser,   // [1:0] cmd, [3:2] fan_index
  // Duty stream, one transaction per tick.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [9:0] fan0_duty, [18:10] fan1_duty,
                                 // [28:19] fan2_duty, [31:29] zero
  output logic [1:0]  m_tuser    // [0] fan1_passthrough, [1] fan2_passthrough
);

  // The control store in the package sequences a small datapath. Step zero
  // waits for a transaction and dispatches on its command. Set-speed runs a
  // two-step program (reciprocal quotient for mod 321, then the write). A
  // tick runs, for each fan, load, multiply, divider setup, sixteen divider
  // steps and a store, then a final step loads the output register. The
  // output register lets the next command in while the result waits.

  // --------------------------------------------------------------------------
  // Configuration register.
  // --------------------------------------------------------------------------
  logic [15:0] dur;

  always_ff @(posedge clk) begin
    if (rst) begin
      dur <= '0;
    end else if (cfg_we) begin
      dur <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  tfdr_pkg::pc_t    pc;
  tfdr_pkg::pc_t    pc_next;
  tfdr_pkg::uword_t uw;
  logic             in_acc;
  logic             out_free;
  logic [1:0]       cmd;
  logic [1:0]       fan_in;
  logic             div_last;

  assign uw       = tfdr_pkg::ucode(pc);
  assign cmd      = s_tuser[1:0];
  assign fan_in   = s_tuser[3:2];
  assign s_tready = (pc == tfdr_pkg::PC_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    pc_next = pc + 1'b1;
    unique case (uw.jmp)
      tfdr_pkg::JMP_NEXT: begin
        pc_next = pc + 1'b1;
      end
      tfdr_pkg::JMP_ALWAYS: begin
        pc_next = uw.target;
      end
      tfdr_pkg::JMP_DISPATCH: begin
        pc_next = uw.target;
        if (in_acc && cmd == tfdr_pkg::CMD_TICK) begin
          pc_next = tfdr_pkg::PC_TICK;
        end else if (in_acc && cmd == tfdr_pkg::CMD_SET && fan_in != tfdr_pkg::FAN_LIMIT) begin
          pc_next = tfdr_pkg::PC_SET;
        end
      end
      tfdr_pkg::JMP_DIV_LOOP: begin
        pc_next = div_last ? pc + 1'b1 : uw.target;
      end
      tfdr_pkg::JMP_OUT_WAIT: begin
        pc_next = out_free ? uw.target : pc;
      end
      default: begin
        pc_next = tfdr_pkg::PC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= tfdr_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Decode the control word into datapath enables.
  logic                modq_en;
  logic                write_en;
  logic                load_en;
  logic                mul_en;
  logic                store_en;
  logic                emit_en;
  tfdr_pkg::div_ctrl_t div_ctrl;

  always_comb begin
    modq_en       = 1'b0;
    write_en      = 1'b0;
    load_en       = 1'b0;
    mul_en        = 1'b0;
    store_en      = 1'b0;
    emit_en       = 1'b0;
    div_ctrl      = '0;
    unique case (uw.op)
      tfdr_pkg::OP_NOP:   begin end
      tfdr_pkg::OP_MODQ:  modq_en       = 1'b1;
      tfdr_pkg::OP_WRITE: write_en      = 1'b1;
      tfdr_pkg::OP_LOAD:  load_en       = 1'b1;
      tfdr_pkg::OP_MUL:   mul_en        = 1'b1;
      tfdr_pkg::OP_DINIT: div_ctrl.init = 1'b1;
      tfdr_pkg::OP_DSTEP: div_ctrl.step = 1'b1;
      tfdr_pkg::OP_STORE: store_en      = 1'b1;
      tfdr_pkg::OP_EMIT:  emit_en       = out_free;
      default:            begin end
    endcase
  end

  // --------------------------------------------------------------------------
  // Command capture and millisecond count.
  // --------------------------------------------------------------------------
  logic [1:0]  fan_r;
  logic [15:0] speed_r;
  logic [16:0] elapsed;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fan_r   <= fan_in;
      speed_r <= s_tdata;
    end
  end

  // The tick advances the count before the ramp is evaluated, so the
  // program always sees the new value.
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (in_acc && cmd == tfdr_pkg::CMD_RESTART) begin
      elapsed <= '0;
    end else if (in_acc && cmd == tfdr_pkg::CMD_TICK && elapsed != tfdr_pkg::ELAPSED_MAX) begin
      elapsed <= elapsed + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Fan targets. Set-speed moves the current target to the previous one.
  // --------------------------------------------------------------------------
  logic [15:0] target   [tfdr_pkg::FAN_COUNT];
  logic [15:0] previous [tfdr_pkg::FAN_COUNT];
  logic [31:0] modq_prod;
  logic [7:0]  mod_q;
  logic [16:0] mod_rem;
  logic [15:0] wr_val;

  // Reciprocal multiply gives speed / 321; the remainder follows next step.
  assign modq_prod = 32'(speed_r) * 32'(tfdr_pkg::MOD321_RECIP);

  always_ff @(posedge clk) begin
    if (modq_en) begin
      mod_q <= modq_prod[tfdr_pkg::MOD321_SHIFT +: 8];
    end
  end

  assign mod_rem = {1'b0, speed_r} - 17'(17'(mod_q) * tfdr_pkg::MOD321);

  // Fan 0 never goes to passthrough; fans 1 and 2 keep the all-ones code.
  always_comb begin
    if (fan_r == 2'd0) begin
      wr_val = {7'd0, mod_rem[8:0]};
    end else if (speed_r == tfdr_pkg::PASSTHROUGH) begin
      wr_val = tfdr_pkg::PASSTHROUGH;
    end else if (fan_r == 2'd1) begin
      wr_val = {8'd0, speed_r[7:0]};
    end else begin
      wr_val = {7'd0, mod_rem[8:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target[0]   <= tfdr_pkg::FAN0_RESET;
      target[1]   <= tfdr_pkg::PASSTHROUGH;
      target[2]   <= tfdr_pkg::PASSTHROUGH;
      previous[0] <= tfdr_pkg::FAN0_RESET;
      previous[1] <= tfdr_pkg::PASSTHROUGH;
      previous[2] <= tfdr_pkg::PASSTHROUGH;
    end else if (write_en) begin
      previous[fan_r] <= target[fan_r];
      target[fan_r]   <= wr_val;
    end
  end

  // --------------------------------------------------------------------------
  // Ramp datapath: last + (target - last) * elapsed / duration, computed on
  // magnitudes so the divider truncates toward zero, then the sign returns.
  // Targets are read as 16-bit two's complement, so passthrough counts as -1.
  // --------------------------------------------------------------------------
  logic [15:0]        rd_to;
  logic [15:0]        rd_from;
  logic signed [16:0] diff;
  logic [16:0]        diff_neg;
  logic               load_bypass;

  logic [15:0] op_to;
  logic [15:0] op_from;
  logic        op_neg;
  logic [15:0] op_mag;
  logic        op_bypass;
  logic [31:0] prod;
  logic [15:0] quo;

  assign rd_to       = target[uw.fan];
  assign rd_from     = previous[uw.fan];
  assign diff        = $signed({rd_to[15], rd_to}) - $signed({rd_from[15], rd_from});
  assign diff_neg    = 17'(-diff);
  // Past the end of the ramp, or with no ramp at all, the target applies.
  assign load_bypass = (dur == '0) || (elapsed > {1'b0, dur});

  always_ff @(posedge clk) begin
    if (load_en) begin
      op_to     <= rd_to;
      op_from   <= rd_from;
      op_neg    <= diff[16];
      op_mag    <= diff[16] ? diff_neg[15:0] : diff[15:0];
      op_bypass <= load_bypass;
    end
  end

  // When the ramp is live, elapsed does not exceed the 16-bit duration.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= 32'(op_mag) * 32'(elapsed[15:0]);
    end
  end

  tfdr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (prod),
    .divisor  (dur),
    .quotient (quo),
    .last     (div_last)
  );

  logic [17:0] quo_x;
  logic [17:0] ramp;

  assign quo_x = {2'd0, quo};
  assign ramp  = op_bypass ? {{2{op_to[15]}}, op_to}
                           : {{2{op_from[15]}}, op_from} + (op_neg ? 18'(-quo_x) : quo_x);

  logic [9:0] duty0;
  logic [8:0] duty1;
  logic [9:0] duty2;

  always_ff @(posedge clk) begin
    if (store_en) begin
      case (uw.fan)
        2'd0:    duty0 <= ramp[9:0];
        2'd1:    duty1 <= ramp[8:0];
        default: duty2 <= ramp[9:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register. A fan in passthrough reports a zero duty.
  // --------------------------------------------------------------------------
  logic pass1;
  logic pass2;

  assign pass1 = (target[1] == tfdr_pkg::PASSTHROUGH);
  assign pass2 = (target[2] == tfdr_pkg::PASSTHROUGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      m_tdata <= {3'd0, pass2 ? 10'd0 : duty2, pass1 ? 9'd0 : duty1, duty0};
      m_tuser <= {pass2, pass1};
    end
  end

`ifndef SYNTHESIS
  // The program counter stays inside the control store.
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= tfdr_pkg::PC_LAST)
    else $error("sequencer left the control store");

  // An accepted tick must start the ramp program.
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && cmd == tfdr_pkg::CMD_TICK) |=> (pc == tfdr_pkg::PC_TICK))
    else $error("tick did not start the ramp program");

  // The count only moves back on a restart.
  a_elapsed_mono: assert property (@(posedge clk) disable iff (rst)
    !(in_acc && cmd == tfdr_pkg::CMD_RESTART) |=> elapsed >= $past(elapsed))
    else $error("millisecond count went backward");

  // A result reporting passthrough carries zero duty for that fan.
  a_pass_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[0] || m_tuser[1])) |->
      ((!m_tuser[0] || m_tdata[18:10] == 9'd0) && (!m_tuser[1] || m_tdata[28:19] == 10'd0)))
    else $error("passthrough fan reported a nonzero duty");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for three_fan_duty_ramp_unit
// Drives set-speed, restart and tick commands over the command stream, keeps
// a cycle-free predictor of the three fan targets and the ramp count, and
// checks every duty transaction against it under random source gaps, random
// sink stalls and a range of ramp durations written between phases.
// ----------------------------------------------------------------------------
module tb;

  // The only command code the package leaves unnamed; the block ignores it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Target ranges of the fans: fan 0 and fan 2 out of 320, fan 1 out of 255.
  localparam int WIDE_MOD   = 321;
  localparam int NARROW_MOD = 256;

  // Covers any work still going on inside the block after the last duty transaction.
  localparam int SETTLE_CYCLES = 80;
  // Cycles without any transaction on either stream before the run is
  // declared hung.
  localparam int QUIET_LIMIT   = 4000;

  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 100;

  // One command as it travels on the command stream.
  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  fan;
    logic [15:0] speed;
    bit          wait_drain;  // hold this command until no duty is pending
  } fan_cmd_t;

  // One duty transaction as the block should send it.
  typedef struct packed {
    logic [9:0] fan0;
    logic [8:0] fan1;
    logic       pass1;
    logic [9:0] fan2;
    logic       pass2;
  } duty_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_SPOTTY,
    SINK_BLOCKY
  } sink_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  three_fan_duty_ramp_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predicted state of the block: targets, previous targets, the ramp count
  // and the programmed duration.
  // --------------------------------------------------------------------------
  logic [15:0] fan_target [tfdr_pkg::FAN_COUNT];
  logic [15:0] fan_last   [tfdr_pkg::FAN_COUNT];
  logic [16:0] ramp_ms;
  logic [15:0] ramp_len;

  fan_cmd_t pending_cmds[$];   // commands not yet presented to the block
  duty_t    expected_duty[$];  // duty transactions the block still owes

  int cmds_queued   = 0;
  int cmds_accepted = 0;
  int ticks_sent    = 0;
  int duties_seen   = 0;
  int ramp_settings = 0;
  int err_count     = 0;
  int quiet_cycles  = 0;

  // Linear interpolation from the previous target to the current one. Both
  // are read as 16-bit two's complement, so a passthrough origin counts as -1.
  // The division truncates toward zero, as SystemVerilog int division does.
  function automatic int ramp_point(logic [15:0] goal, logic [15:0] origin);
    int to_v;
    int from_v;
    int span;
    int elapsed;
    to_v    = $signed(goal);
    from_v  = $signed(origin);
    span    = ramp_len;
    elapsed = ramp_ms;
    if (span == 0 || elapsed > span)
      return to_v;
    return from_v + ((to_v - from_v) * elapsed) / span;
  endfunction

  // Applies one accepted command to the predicted state and, for a tick,
  // queues the duty transaction it must produce.
  task automatic advance_fans(fan_cmd_t c);
    duty_t d;
    int    d0;
    int    d1;
    int    d2;
    case (c.cmd)
      tfdr_pkg::CMD_SET: begin
        if (c.fan != tfdr_pkg::FAN_LIMIT) begin
          fan_last[c.fan] = fan_target[c.fan];
          if (c.fan == 2'd0)
            fan_target[0] = 16'(c.speed % WIDE_MOD);
          else if (c.speed == tfdr_pkg::PASSTHROUGH)
            fan_target[c.fan] = tfdr_pkg::PASSTHROUGH;
          else if (c.fan == 2'd1)
            fan_target[1] = 16'(c.speed % NARROW_MOD);
          else
            fan_target[2] = 16'(c.speed % WIDE_MOD);
        end
      end
      tfdr_pkg::CMD_RESTART: begin
        ramp_ms = '0;
      end
      tfdr_pkg::CMD_TICK: begin
        // The count advances before the duties are worked out.
        if (ramp_ms != tfdr_pkg::ELAPSED_MAX)
          ramp_ms = ramp_ms + 17'd1;
        d0 = ramp_point(fan_target[0], fan_last[0]);
        d1 = ramp_point(fan_target[1], fan_last[1]);
        d2 = ramp_point(fan_target[2], fan_last[2]);
        d.pass1 = (fan_target[1] == tfdr_pkg::PASSTHROUGH);
        d.pass2 = (fan_target[2] == tfdr_pkg::PASSTHROUGH);
        d.fan0  = d0[9:0];
        // A fan under motherboard control reports a zero duty.
        d.fan1  = d.pass1 ? '0 : d1[8:0];
        d.fan2  = d.pass2 ? '0 : d2[9:0];
        expected_duty.push_back(d);
      end
      default: begin
        // The unused command changes nothing.
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers used by the sequence below.
  // --------------------------------------------------------------------------
  task automatic push_cmd(logic [1:0] cmd, logic [1:0] fan, logic [15:0] speed,
                          bit wait_drain = 1'b0);
    fan_cmd_t c;
    c.cmd        = cmd;
    c.fan        = fan;
    c.speed      = speed;
    c.wait_drain = wait_drain;
    pending_cmds.push_back(c);
    cmds_queued++;
    if (cmd == tfdr_pkg::CMD_TICK)
      ticks_sent++;
  endtask

  // Waits until every queued command has been taken and every duty has come
  // back, then lets the block finish any set-speed work still in progress.
  task automatic settle();
    do
      @(posedge clk);
    while (!(cmds_accepted == cmds_queued && expected_duty.size() == 0));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the ramp duration; only called while the block is idle, so the
  // predictor can take the new value at once.
  task automatic write_ramp_len(logic [15:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    ramp_len = value;
    ramp_settings++;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Random commands, mostly set-speed and tick so that ramps are exercised,
  // with restarts, out-of-range fans and the unused command mixed in. One
  // command in the middle holds the source until all duties are back.
  task automatic add_random_cmds(int count);
    int          pick;
    int          sel;
    logic [1:0]  fan;
    logic [15:0] speed;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      fan  = ($urandom_range(0, 9) == 0) ? tfdr_pkg::FAN_LIMIT : 2'($urandom_range(0, 2));
      sel  = $urandom_range(0, 9);
      if (sel < 2)
        speed = tfdr_pkg::PASSTHROUGH;
      else if (sel < 6)
        speed = 16'($urandom_range(0, 400));
      else if (sel == 6)
        speed = 16'($urandom_range(250, 330));
      else
        speed = 16'($urandom);
      if (pick < 38)
        push_cmd(tfdr_pkg::CMD_SET, fan, speed, i == count / 2);
      else if (pick < 45)
        push_cmd(tfdr_pkg::CMD_RESTART, fan, speed, i == count / 2);
      else if (pick < 96)
        push_cmd(tfdr_pkg::CMD_TICK, fan, speed, i == count / 2);
      else
        push_cmd(CMD_UNUSED, 2'($urandom), 16'($urandom), i == count / 2);
    end
  endtask

  // --------------------------------------------------------------------------
  // Source driver: presents queued commands in bursts of random length with
  // random gaps, holding each one until the block takes it.
  // --------------------------------------------------------------------------
  fan_cmd_t cur_cmd;
  int       burst_left = 0;
  int       gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // Prediction happens at the edge where the transaction completes.
      if (s_tvalid && s_tready) begin
        advance_fans(cur_cmd);
        cmds_accepted++;
      end
      if (s_tvalid && !s_tready) begin
        // Keep the current command on the bus.
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].wait_drain && expected_duty.size() != 0)) begin
        cur_cmd = pending_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= cur_cmd.speed;
        s_tuser  <= {cur_cmd.fan, cur_cmd.cmd};
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink monitor: checks each duty transaction against the oldest prediction
  // and stalls the block in modes that change at random intervals.
  // --------------------------------------------------------------------------
  sink_mode_t sink_mode = SINK_OPEN;
  int         mode_left = 0;
  int         hold_left = 0;
  logic       sink_ready;
  duty_t      want;

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        duties_seen++;
        if (expected_duty.size() == 0) begin
          $error("duty transaction with no tick pending: tdata 0x%0h tuser 0x%0h",
                 m_tdata, m_tuser);
          err_count++;
        end else begin
          want = expected_duty.pop_front();
          check_field("fan0_duty", want.fan0, m_tdata[9:0]);
          check_field("fan1_duty", want.fan1, m_tdata[18:10]);
          check_field("fan2_duty", want.fan2, m_tdata[28:19]);
          check_field("tdata_pad", 0, m_tdata[31:29]);
          check_field("fan1_passthrough", want.pass1, m_tuser[0]);
          check_field("fan2_passthrough", want.pass2, m_tuser[1]);
        end
      end
      if (mode_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(64, 400);
      end else begin
        mode_left--;
      end
      case (sink_mode)
        SINK_OPEN: begin
          sink_ready = 1'b1;
        end
        SINK_SPOTTY: begin
          sink_ready = ($urandom_range(0, 3) != 0);
        end
        default: begin
          // Long stalls now and then, otherwise ready.
          if (hold_left > 0) begin
            hold_left--;
            sink_ready = 1'b0;
          end else begin
            sink_ready = 1'b1;
            if ($urandom_range(0, 7) == 0)
              hold_left = $urandom_range(5, 30);
          end
        end
      endcase
      m_tready <= sink_ready;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a run that stops moving on both streams is a failure.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: %0d cycles without a transaction", QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : sequence_main
    int phase_len [RANDOM_PHASES];

    // Reset values of the block.
    fan_target[0] = tfdr_pkg::FAN0_RESET;
    fan_target[1] = tfdr_pkg::PASSTHROUGH;
    fan_target[2] = tfdr_pkg::PASSTHROUGH;
    fan_last[0]   = tfdr_pkg::FAN0_RESET;
    fan_last[1]   = tfdr_pkg::PASSTHROUGH;
    fan_last[2]   = tfdr_pkg::PASSTHROUGH;
    ramp_ms       = '0;
    ramp_len      = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Duration zero from reset: every duty jumps straight to its target.
    // The first tick shows the reset targets; fan 0 takes 65535 as an
    // ordinary speed, fan 3 and the unused command are ignored.
    push_cmd(tfdr_pkg::CMD_TICK, 2'd0, 16'd0);
    push_cmd(tfdr_pkg::CMD_SET, 2'd0, 16'hFFFF);
    push_cmd(tfdr_pkg::CMD_SET, tfdr_pkg::FAN_LIMIT, 16'd100);
    push_cmd(CMD_UNUSED, 2'd1, 16'd1234);
    push_cmd(tfdr_pkg::CMD_TICK, 2'd0, 16'd0);
    push_cmd(tfdr_pkg::CMD_SET, 2'd1, 16'd255);
    push_cmd(tfdr_pkg::CMD_SET, 2'd2, tfdr_pkg::PASSTHROUGH);
    push_cmd(tfdr_pkg::CMD_TICK, 2'd0, 16'd0);
    push_cmd(tfdr_pkg::CMD_SET, 2'd2, 16'd321);
    push_cmd(tfdr_pkg::CMD_SET, 2'd1, 16'd256);
    push_cmd(tfdr_pkg::CMD_TICK, 2'd0, 16'd0);
    settle();

    // A short ramp that runs past its end; fan 2 ramps up from a
    // passthrough origin, which counts as -1.
    write_ramp_len(16'd4);
    push_cmd(tfdr_pkg::CMD_RESTART, 2'd0, 16'd0);
    push_cmd(tfdr_pkg::CMD_SET, 2'd0, 16'd320);
    push_cmd(tfdr_pkg::CMD_SET, 2'd1, tfdr_pkg::PASSTHROUGH);
    push_cmd(tfdr_pkg::CMD_SET, 2'd2, tfdr_pkg::PASSTHROUGH);
    push_cmd(tfdr_pkg::CMD_SET, 2'd2, 16'd10);
    repeat (5) push_cmd(tfdr_pkg::CMD_TICK, 2'd0, 16'd0);
    settle();

    // The longest duration: the ramp barely moves from its origin.
    write_ramp_len(16'hFFFF);
    push_cmd(tfdr_pkg::CMD_RESTART, 2'd0, 16'd0);
    push_cmd(tfdr_pkg::CMD_SET, 2'd0, 16'd0);
    push_cmd(tfdr_pkg::CMD_TICK, 2'd0, 16'd0);
    push_cmd(tfdr_pkg::CMD_TICK, 2'd0, 16'd0);
    settle();

    // Random phases over several durations, the extremes and a value with
    // the top bit set among them. The count is not cleared by the write, so
    // some phases start without a restart.
    phase_len[0] = 0;
    phase_len[1] = 1;
    phase_len[2] = 16'hFFFF;
    phase_len[3] = 16'h8000;
    phase_len[4] = $urandom_range(2, 60);
    phase_len[5] = $urandom_range(2, 200);
    phase_len[6] = $urandom_range(0, 65535);
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_ramp_len(16'(phase_len[p]));
      if ($urandom_range(0, 1) == 0)
        push_cmd(tfdr_pkg::CMD_RESTART, 2'd0, 16'd0);
      add_random_cmds(PHASE_ITEMS);
      settle();
    end

    $display("Sent %0d commands (%0d ticks) over %0d ramp duration settings;",
             cmds_accepted, ticks_sent, ramp_settings);
    $display("checked %0d duty transactions, %0d mismatches.", duties_seen, err_count);
    if (err_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
hdl/tfdr_pkg.sv
hdl/tfdr_divider.sv
hdl/three_fan_duty_ramp_unit.sv
tb/tb.sv
